// ===== design/sssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants of the shortest-path core
// Field widths, register indexes, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package sssp_pkg;

  // Fixed field widths of the external interface
  localparam int VTX_W         = 6;
  localparam int VCOUNT_W      = 7;
  localparam int WEIGHT_PORT_W = 16;
  localparam int DIST_W        = 22;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  localparam logic [DIST_W-1:0]   DIST_MAX     = 22'h3F_FFFF;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;

  // Input opcodes
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX_RD,
    ST_RELAX_EDGE,
    ST_RELAX_UPD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } sssp_state_t;

endpackage

// ===== design/single_source_shortest_paths_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_paths_core: shortest distances from one source vertex
// Edge store, linear minimum scan and edge relaxation under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 appends one directed edge to
//   the edge store; opcode 1 starts a run. Edge transactions are taken one per
//   cycle while idle. Edges arriving with the store full are dropped and
//   flagged on every result of the next run.
//   A run computes distances from source_vertex over vertex_count vertices,
//   then emits one result per vertex in index order on the output channel
//   (out_valid / out_stall), last_vertex marking the final one. The run
//   empties the edge store. in_stall is high for the whole run.
//   The single read ports of the edge store and the distance memory set the
//   run's pace: every edge is walked per settled vertex, every vertex per scan.
//   A result waits in the output register while out_stall is high; the
//   sequencer holds until the register frees.
//   Configuration (cfg_valid / cfg_ready) is taken in any cycle and is meant
//   to be written while the block is idle. Reset (synchronous, rst_n low)
//   empties the edge store, clears the overflow flag and restores
//   vertex_count = 64, source_vertex = 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [sssp_pkg::VTX_W-1:0]           in_edge_from,
  input  logic [sssp_pkg::VTX_W-1:0]           in_edge_to,
  input  logic [sssp_pkg::WEIGHT_PORT_W-1:0]   in_edge_weight,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sssp_pkg::VTX_W-1:0]           out_vertex_index,
  output logic [sssp_pkg::DIST_W-1:0]          out_distance,
  output logic                                 out_reachable,
  output logic                                 out_edges_dropped,
  output logic                                 out_last_vertex,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sssp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sssp_pkg::*;

  // Derived widths
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EC_W   = $clog2(MAX_EDGES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int WT_W   = (WEIGHT_BITS < WEIGHT_PORT_W) ? WEIGHT_BITS : WEIGHT_PORT_W;
  localparam int SUM_W  = DIST_W + 1;

  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic [WT_W-1:0]  wt;
  } edge_rec_t;

  // Storage
  edge_rec_t          edge_mem [MAX_EDGES];
  logic [DIST_W-1:0]  best_mem [MAX_VERTICES];

  // Control and payload registers
  sssp_state_t         state_r, state_nxt;
  logic [VCOUNT_W-1:0] vertex_count_r;
  logic [VTX_W-1:0]    source_r;
  logic [EC_W-1:0]     edge_count_r, edge_count_nxt;
  logic                overflow_r, overflow_nxt;
  logic                dropped_r, dropped_nxt;
  logic [VCNT_W-1:0]   n_r, n_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] settled_r, settled_nxt;
  logic [VCNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [VIDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                pick_vld_r, pick_vld_nxt;
  logic [VIDX_W-1:0]   pick_r, pick_nxt;
  logic [DIST_W-1:0]   pick_d_r, pick_d_nxt;
  logic [EC_W-1:0]     e_idx_r, e_idx_nxt;
  logic [DIST_W-1:0]   sum_r, sum_nxt;
  logic [VIDX_W-1:0]   emit_idx_r, emit_idx_nxt;
  edge_rec_t           edge_rd_r;
  logic [DIST_W-1:0]   best_rd_r;

  logic                out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]    out_vertex_r, out_vertex_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic                out_reach_r, out_reach_nxt;
  logic                out_drop_r, out_drop_nxt;
  logic                out_last_r, out_last_nxt;

  // Memory port controls
  logic                edge_we, edge_re;
  logic [EA_W-1:0]     edge_ra;
  edge_rec_t           edge_wd;
  logic                best_we, best_re;
  logic [VIDX_W-1:0]   best_wa, best_ra;
  logic [DIST_W-1:0]   best_wd;

  // Shared condition signals
  logic                in_acc;
  logic                src_ok;
  logic                scan_done;
  logic                edge_more;
  logic                edge_hit;
  logic                out_free;
  logic                emit_last;
  logic [VCNT_W-1:0]   n_calc;
  logic [VCNT_W-1:0]   n_m1;
  logic [VIDX_W-1:0]   dst_idx;
  logic [SUM_W-1:0]    sum_full;
  logic                cmp_better;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // Clamp the configured vertex count to 1 .. MAX_VERTICES
  always_comb begin
    if (vertex_count_r == '0) begin
      n_calc = VCNT_W'(1);
    end else if (vertex_count_r > VCOUNT_W'(MAX_VERTICES)) begin
      n_calc = VCNT_W'(MAX_VERTICES);
    end else begin
      n_calc = VCNT_W'(vertex_count_r);
    end
  end

  assign n_m1      = n_r - VCNT_W'(1);
  assign src_ok    = ({1'b0, source_r} < VCOUNT_W'(n_r));
  assign scan_done = (scan_idx_r == n_r) && !cmp_vld_r;
  assign edge_more = (e_idx_r < edge_count_r);
  assign edge_hit  = (edge_rd_r.src == VTX_W'(pick_r)) &&
                     ({1'b0, edge_rd_r.dst} < VCOUNT_W'(n_r));
  assign dst_idx   = edge_rd_r.dst[VIDX_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (VCNT_W'(emit_idx_r) == n_m1);
  assign sum_full  = SUM_W'(pick_d_r) + SUM_W'(edge_rd_r.wt);
  assign cmp_better = reached_r[cmp_idx_r] && !settled_r[cmp_idx_r] &&
                      (!pick_vld_r || (best_rd_r < pick_d_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OP_RUN)) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = src_ok ? ST_SCAN : ST_EMIT_RD;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = pick_vld_r ? ST_RELAX_RD : ST_EMIT_RD;
      end
      ST_RELAX_RD: begin
        state_nxt = edge_more ? ST_RELAX_EDGE : ST_SCAN;
      end
      ST_RELAX_EDGE: begin
        state_nxt = edge_hit ? ST_RELAX_UPD : ST_RELAX_RD;
      end
      ST_RELAX_UPD: begin
        state_nxt = ST_RELAX_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    edge_count_nxt = edge_count_r;
    overflow_nxt   = overflow_r;
    dropped_nxt    = dropped_r;
    n_nxt          = n_r;
    reached_nxt    = reached_r;
    settled_nxt    = settled_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    pick_vld_nxt   = pick_vld_r;
    pick_nxt       = pick_r;
    pick_d_nxt     = pick_d_r;
    e_idx_nxt      = e_idx_r;
    sum_nxt        = sum_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r;
    out_vertex_nxt = out_vertex_r;
    out_dist_nxt   = out_dist_r;
    out_reach_nxt  = out_reach_r;
    out_drop_nxt   = out_drop_r;
    out_last_nxt   = out_last_r;
    edge_we        = 1'b0;
    edge_re        = 1'b0;
    edge_ra        = e_idx_r[EA_W-1:0];
    edge_wd.src    = in_edge_from;
    edge_wd.dst    = in_edge_to;
    edge_wd.wt     = in_edge_weight[WT_W-1:0];
    best_we        = 1'b0;
    best_re        = 1'b0;
    best_wa        = dst_idx;
    best_wd        = sum_r;
    best_ra        = emit_idx_r;

    // output register drains when taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_ADD_EDGE) begin
            if (edge_count_r < EC_W'(MAX_EDGES)) begin
              edge_we        = 1'b1;
              edge_count_nxt = edge_count_r + EC_W'(1);
            end else begin
              overflow_nxt = 1'b1;
            end
          end else begin
            n_nxt        = n_calc;
            dropped_nxt  = overflow_r;
            overflow_nxt = 1'b0;
            reached_nxt  = '0;
            settled_nxt  = '0;
          end
        end
      end
      ST_INIT: begin
        scan_idx_nxt = '0;
        cmp_vld_nxt  = 1'b0;
        pick_vld_nxt = 1'b0;
        emit_idx_nxt = '0;
        if (src_ok) begin
          reached_nxt[source_r[VIDX_W-1:0]] = 1'b1;
          best_we = 1'b1;
          best_wa = source_r[VIDX_W-1:0];
          best_wd = '0;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the previous read's data
        if (scan_idx_r < n_r) begin
          best_re      = 1'b1;
          best_ra      = scan_idx_r[VIDX_W-1:0];
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[VIDX_W-1:0];
          scan_idx_nxt = scan_idx_r + VCNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r && cmp_better) begin
          pick_vld_nxt = 1'b1;
          pick_nxt     = cmp_idx_r;
          pick_d_nxt   = best_rd_r;
        end
      end
      ST_PICK: begin
        e_idx_nxt    = '0;
        emit_idx_nxt = '0;
        if (pick_vld_r) settled_nxt[pick_r] = 1'b1;
      end
      ST_RELAX_RD: begin
        if (edge_more) begin
          edge_re = 1'b1;
        end else begin
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          pick_vld_nxt = 1'b0;
        end
      end
      ST_RELAX_EDGE: begin
        if (edge_hit) begin
          best_re = 1'b1;
          best_ra = dst_idx;
          sum_nxt = (sum_full > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_full[DIST_W-1:0];
        end else begin
          e_idx_nxt = e_idx_r + EC_W'(1);
        end
      end
      ST_RELAX_UPD: begin
        if (!reached_r[dst_idx] || (sum_r < best_rd_r)) begin
          reached_nxt[dst_idx] = 1'b1;
          best_we = 1'b1;
        end
        e_idx_nxt = e_idx_r + EC_W'(1);
      end
      ST_EMIT_RD: begin
        best_re = 1'b1;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = VTX_W'(emit_idx_r);
          out_reach_nxt  = reached_r[emit_idx_r];
          out_dist_nxt   = reached_r[emit_idx_r] ? best_rd_r : '0;
          out_drop_nxt   = dropped_r;
          out_last_nxt   = emit_last;
          if (emit_last) begin
            edge_count_nxt = '0;
          end else begin
            emit_idx_nxt = emit_idx_r + VIDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Edge store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_count_r[EA_W-1:0]] <= edge_wd;
    if (edge_re) edge_rd_r <= edge_mem[edge_ra];
  end

  // Tentative distance memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    if (best_re) best_rd_r <= best_mem[best_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      vertex_count_r <= VCOUNT_RESET;
      source_r       <= '0;
      edge_count_r   <= '0;
      overflow_r     <= 1'b0;
      reached_r      <= '0;
      settled_r      <= '0;
      cmp_vld_r      <= 1'b0;
      pick_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      overflow_r   <= overflow_nxt;
      reached_r    <= reached_nxt;
      settled_r    <= settled_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      pick_vld_r   <= pick_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT:  vertex_count_r <= cfg_data[VCOUNT_W-1:0];
          CFG_SOURCE_VERTEX: source_r       <= cfg_data[VTX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dropped_r    <= dropped_nxt;
    n_r          <= n_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pick_r       <= pick_nxt;
    pick_d_r     <= pick_d_nxt;
    e_idx_r      <= e_idx_nxt;
    sum_r        <= sum_nxt;
    emit_idx_r   <= emit_idx_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_dist_r   <= out_dist_nxt;
    out_reach_r  <= out_reach_nxt;
    out_drop_r   <= out_drop_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_index  = out_vertex_r;
  assign out_distance      = out_dist_r;
  assign out_reachable     = out_reach_r;
  assign out_edges_dropped = out_drop_r;
  assign out_last_vertex   = out_last_r;

endmodule

// ===== design/sssp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_checker: port-level checks for the shortest-path core
// Watches handshakes and result sequencing; bound to the top level.
// ----------------------------------------------------------------------------
module sssp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_opcode,
  input logic [sssp_pkg::VTX_W-1:0]         in_edge_from,
  input logic [sssp_pkg::VTX_W-1:0]         in_edge_to,
  input logic [sssp_pkg::WEIGHT_PORT_W-1:0] in_edge_weight,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [sssp_pkg::VTX_W-1:0]         out_vertex_index,
  input logic [sssp_pkg::DIST_W-1:0]        out_distance,
  input logic                               out_reachable,
  input logic                               out_edges_dropped,
  input logic                               out_last_vertex
);
  import sssp_pkg::*;

  // A stalled input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_opcode) && $stable(in_edge_from) &&
      $stable(in_edge_to) && $stable(in_edge_weight))
    else $error("input changed while stalled");

  // A stalled result holds its transaction unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index) &&
      $stable(out_distance) && $stable(out_reachable) &&
      $stable(out_edges_dropped) && $stable(out_last_vertex))
    else $error("result changed while stalled");

  // A run transaction makes the block busy on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_RUN) |=> in_stall)
    else $error("block not busy after run transaction");

  // A pending non-final result means the run is still in progress
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_vertex |-> in_stall)
    else $error("non-final result pending while idle");

  // Reset leaves the block idle with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind single_source_shortest_paths_core sssp_checker u_sssp_checker (.*);
